// File: hdl/q2e_pkg.sv
package q2e_pkg;

   // product of two Q2.30 values cut to Q.30
   localparam int PROD_W = 34;
   // atan2 operands of roll and yaw
   localparam int T_W = 37;
   // clamped asin argument
   localparam int T2_W = 32;
   // radicand of the square root, Q.60
   localparam int SQ_W = 62;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W = SQRT_STEPS;
   localparam int REM_W = ROOT_W + 2;
   // CORDIC vector and angle accumulator (degrees * 65536)
   localparam int CX_W = 40;
   localparam int ACC_W = 26;
   localparam int MAX_STEPS = 30;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int OUT_W = 17;
   localparam int PITCH_W = 16;

   localparam logic signed [ACC_W-1:0] DEG90_ACC = ACC_W'(90 * 65536);
   localparam logic signed [OUT_W-1:0] ROLL_LIM = OUT_W'(46080);
   localparam logic signed [OUT_W-1:0] PITCH_LIM = OUT_W'(23040);
   localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(1) << 60;
   localparam logic signed [T_W-1:0] ONE_Q30 = T_W'(1) << 30;

   typedef struct packed {
      logic signed [T_W-1:0]  t0;
      logic signed [T_W-1:0]  t1;
      logic signed [T_W-1:0]  t3;
      logic signed [T_W-1:0]  t4;
      logic signed [T2_W-1:0] t2;
   } aux_type;

   typedef struct packed {
      logic              valid;
      aux_type           aux;
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_lane_type;

   typedef struct packed {
      logic                    zero;
      logic signed [CX_W-1:0]  x;
      logic signed [CX_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
   } chan_type;

   typedef struct packed {
      logic     valid;
      chan_type roll;
      chan_type pitch;
      chan_type yaw;
   } cordic_lane_type;

   // atan(2^-i) in degrees * 65536
   function automatic logic signed [ACC_W-1:0] atan_angle(input int i);
      logic signed [ACC_W-1:0] a;
      unique case (i)
         0:  a = ACC_W'(2949120);
         1:  a = ACC_W'(1740967);
         2:  a = ACC_W'(919879);
         3:  a = ACC_W'(466945);
         4:  a = ACC_W'(234379);
         5:  a = ACC_W'(117304);
         6:  a = ACC_W'(58666);
         7:  a = ACC_W'(29335);
         8:  a = ACC_W'(14668);
         9:  a = ACC_W'(7334);
         10: a = ACC_W'(3667);
         11: a = ACC_W'(1833);
         12: a = ACC_W'(917);
         13: a = ACC_W'(458);
         14: a = ACC_W'(229);
         15: a = ACC_W'(115);
         16: a = ACC_W'(57);
         17: a = ACC_W'(29);
         18: a = ACC_W'(14);
         19: a = ACC_W'(7);
         20: a = ACC_W'(4);
         21: a = ACC_W'(2);
         22: a = ACC_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// File: hdl/q2e_sqrt_cell.sv
module q2e_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  q2e_pkg::sqrt_lane_type lane_i,
   output q2e_pkg::sqrt_lane_type lane_o
);

   q2e_pkg::sqrt_lane_type lane_ff, lane_in;
   logic [q2e_pkg::REM_W+1:0] r, trial;

   // take the next two radicand bits and settle one root bit
   always_comb begin
      r = {lane_i.rem, lane_i.rad[q2e_pkg::SQ_W-1 -: 2]};
      trial = {2'b00, lane_i.root, 2'b01};
      lane_in = lane_i;
      lane_in.rad = lane_i.rad << 2;
      if (r >= trial) begin
         lane_in.rem = q2e_pkg::REM_W'(r - trial);
         lane_in.root = {lane_i.root[q2e_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         lane_in.rem = r[q2e_pkg::REM_W-1:0];
         lane_in.root = {lane_i.root[q2e_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

// File: hdl/q2e_cordic_cell.sv
module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  q2e_pkg::cordic_lane_type lane_i,
   output q2e_pkg::cordic_lane_type lane_o
);

   localparam logic signed [q2e_pkg::ACC_W-1:0] ANGLE = q2e_pkg::atan_angle(STEP);

   q2e_pkg::cordic_lane_type lane_ff, lane_in;

   // one vectoring micro-rotation toward the x axis
   function automatic q2e_pkg::chan_type rotate(input q2e_pkg::chan_type c);
      q2e_pkg::chan_type o;
      logic signed [q2e_pkg::CX_W-1:0] dx, dy;
      o = c;
      dx = c.y >>> STEP;
      dy = c.x >>> STEP;
      if (!c.y[q2e_pkg::CX_W-1]) begin
         o.x = c.x + dx;
         o.y = c.y - dy;
         o.acc = c.acc + ANGLE;
      end else begin
         o.x = c.x - dx;
         o.y = c.y + dy;
         o.acc = c.acc - ANGLE;
      end
      return o;
   endfunction

   always_comb begin
      lane_in.valid = lane_i.valid;
      lane_in.roll = rotate(lane_i.roll);
      lane_in.pitch = rotate(lane_i.pitch);
      lane_in.yaw = rotate(lane_i.yaw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

// File: hdl/quaternion_to_euler_angles.sv
// Quaternion (w, x, y, z, signed Q2.30) to roll, pitch and yaw in degrees * 256.
// Fully pipelined: one request is taken every cycle while rsp_ready does not stall the
// pipeline, and each result passes through one multiply stage, one sum and
// clamp stage, one squaring stage, 31 cells of the digit-by-digit square root
// for the pitch cosine, one quadrant stage, one CORDIC cell per step and the
// rounding stage that drives rsp_*. The square root chain is the longest part
// of the pipeline. A stalled rsp_ready holds the whole pipeline in place.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [31:0]                      req_q_w,
   input  logic signed [31:0]                      req_q_x,
   input  logic signed [31:0]                      req_q_y,
   input  logic signed [31:0]                      req_q_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [q2e_pkg::OUT_W-1:0]        rsp_roll_deg,
   output logic signed [q2e_pkg::PITCH_W-1:0]      rsp_pitch_deg,
   output logic signed [q2e_pkg::OUT_W-1:0]        rsp_yaw_deg
);

   localparam int STEPS = (CORDIC_STEPS > q2e_pkg::MAX_STEPS) ?
                          q2e_pkg::MAX_STEPS : CORDIC_STEPS;
   localparam int PW = q2e_pkg::PROD_W;
   localparam int TW = q2e_pkg::T_W;

   logic en;
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   q2e_pkg::aux_type aux2_ff, aux2_in, aux3_ff;
   logic [q2e_pkg::SQ_W-1:0] sq3_ff;
   logic signed [TW-1:0] t2_raw;
   logic signed [2*q2e_pkg::T2_W-1:0] sq_full;
   q2e_pkg::sqrt_lane_type sq_lane [q2e_pkg::SQRT_STEPS+1];
   q2e_pkg::cordic_lane_type cd_lane [STEPS+1];
   q2e_pkg::cordic_lane_type pre_in;
   q2e_pkg::aux_type aux_s;
   logic signed [q2e_pkg::OUT_W-1:0] roll_in, yaw_in, pitch_full;
   logic signed [q2e_pkg::OUT_W-1:0] roll_ff, yaw_ff;
   logic signed [q2e_pkg::PITCH_W-1:0] pitch_ff;

   // advance everything unless a result waits and rsp_ready is low
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   function automatic logic signed [PW-1:0] mulq(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   // fold left half-plane vectors and flag the null vector
   function automatic q2e_pkg::chan_type prerot(input logic signed [q2e_pkg::CX_W-1:0] y,
                                                input logic signed [q2e_pkg::CX_W-1:0] x);
      q2e_pkg::chan_type c;
      c.zero = (x == '0) && (y == '0);
      c.x = x;
      c.y = y;
      c.acc = '0;
      if (x[q2e_pkg::CX_W-1]) begin
         if (!y[q2e_pkg::CX_W-1]) begin
            c.x = y;
            c.y = -x;
            c.acc = q2e_pkg::DEG90_ACC;
         end else begin
            c.x = -y;
            c.y = x;
            c.acc = -q2e_pkg::DEG90_ACC;
         end
      end
      return c;
   endfunction

   // round to 1/256 degree and saturate
   function automatic logic signed [q2e_pkg::OUT_W-1:0] finish(
         input q2e_pkg::chan_type c, input logic signed [q2e_pkg::OUT_W-1:0] lim);
      logic signed [q2e_pkg::ACC_W:0] s;
      logic signed [q2e_pkg::ACC_W-8:0] d;
      logic signed [q2e_pkg::OUT_W-1:0] o;
      s = (q2e_pkg::ACC_W+1)'(c.acc) + (q2e_pkg::ACC_W+1)'(128);
      d = s[q2e_pkg::ACC_W:8];
      if (c.zero) begin
         o = '0;
      end else if (d > (q2e_pkg::ACC_W-7)'(lim)) begin
         o = lim;
      end else if (d < -(q2e_pkg::ACC_W-7)'(lim)) begin
         o = -lim;
      end else begin
         o = d[q2e_pkg::OUT_W-1:0];
      end
      return o;
   endfunction

   // stage 1: component products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         wx_ff <= mulq(req_q_w, req_q_x);
         yz_ff <= mulq(req_q_y, req_q_z);
         xx_ff <= mulq(req_q_x, req_q_x);
         yy_ff <= mulq(req_q_y, req_q_y);
         wy_ff <= mulq(req_q_w, req_q_y);
         zx_ff <= mulq(req_q_z, req_q_x);
         wz_ff <= mulq(req_q_w, req_q_z);
         xy_ff <= mulq(req_q_x, req_q_y);
         zz_ff <= mulq(req_q_z, req_q_z);
      end
   end

   // stage 2: atan2 operands and the clamped asin argument
   always_comb begin
      aux2_in.t0 = (TW'(wx_ff) + TW'(yz_ff)) <<< 1;
      aux2_in.t1 = q2e_pkg::ONE_Q30 - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
      aux2_in.t3 = (TW'(wz_ff) + TW'(xy_ff)) <<< 1;
      aux2_in.t4 = q2e_pkg::ONE_Q30 - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      t2_raw = (TW'(wy_ff) - TW'(zx_ff)) <<< 1;
      if (t2_raw > q2e_pkg::ONE_Q30) begin
         aux2_in.t2 = q2e_pkg::T2_W'(q2e_pkg::ONE_Q30);
      end else if (t2_raw < -q2e_pkg::ONE_Q30) begin
         aux2_in.t2 = q2e_pkg::T2_W'(-q2e_pkg::ONE_Q30);
      end else begin
         aux2_in.t2 = t2_raw[q2e_pkg::T2_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
         aux2_ff <= aux2_in;
      end
   end

   // stage 3: square the asin argument
   assign sq_full = aux2_ff.t2 * aux2_ff.t2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
         aux3_ff <= aux2_ff;
         sq3_ff <= sq_full[q2e_pkg::SQ_W-1:0];
      end
   end

   // square root chain of 1 - t^2
   always_comb begin
      sq_lane[0].valid = v3_ff;
      sq_lane[0].aux = aux3_ff;
      sq_lane[0].rad = q2e_pkg::ONE_Q60 - sq3_ff;
      sq_lane[0].rem = '0;
      sq_lane[0].root = '0;
   end

   for (genvar k = 0; k < q2e_pkg::SQRT_STEPS; k++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .lane_i (sq_lane[k]),
         .lane_o (sq_lane[k+1])
      );
   end

   // quadrant stage feeding the CORDIC row
   always_comb begin
      aux_s = sq_lane[q2e_pkg::SQRT_STEPS].aux;
      pre_in.valid = sq_lane[q2e_pkg::SQRT_STEPS].valid;
      pre_in.roll = prerot(q2e_pkg::CX_W'(aux_s.t0), q2e_pkg::CX_W'(aux_s.t1));
      pre_in.pitch = prerot(q2e_pkg::CX_W'(aux_s.t2),
         q2e_pkg::CX_W'({1'b0, sq_lane[q2e_pkg::SQRT_STEPS].root}));
      pre_in.yaw = prerot(q2e_pkg::CX_W'(aux_s.t3), q2e_pkg::CX_W'(aux_s.t4));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_lane[0].valid <= 1'b0;
      end else if (en) begin
         cd_lane[0] <= pre_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      q2e_cordic_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .lane_i (cd_lane[i]),
         .lane_o (cd_lane[i+1])
      );
   end

   // round, saturate and hold the result
   assign roll_in = finish(cd_lane[STEPS].roll, q2e_pkg::ROLL_LIM);
   assign pitch_full = finish(cd_lane[STEPS].pitch, q2e_pkg::PITCH_LIM);
   assign yaw_in = finish(cd_lane[STEPS].yaw, q2e_pkg::ROLL_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cd_lane[STEPS].valid;
         roll_ff <= roll_in;
         pitch_ff <= pitch_full[q2e_pkg::PITCH_W-1:0];
         yaw_ff <= yaw_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_deg = roll_ff;
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_yaw_deg = yaw_ff;

endmodule
